/* hdl/bnc_pkg.sv */
// Package for the bracket nesting checker: character codes, status codes,
// the decoded-character struct and the corruption score table.
// No dependencies.
package bnc_pkg;

	// Field widths fixed by the interface.
	localparam int CHAR_W  = 8;
	localparam int SCORE_W = 15;
	localparam int COMP_W  = 38;

	// Bracket characters.
	localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
	localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
	localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
	localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
	localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
	localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
	localparam logic [CHAR_W-1:0] CH_LANGLE = 8'h3C;
	localparam logic [CHAR_W-1:0] CH_RANGLE = 8'h3E;

	// Closer codes as kept on the stack.
	localparam logic [1:0] CODE_PAREN = 2'd0;
	localparam logic [1:0] CODE_BRACK = 2'd1;
	localparam logic [1:0] CODE_BRACE = 2'd2;
	localparam logic [1:0] CODE_ANGLE = 2'd3;

	// Line status codes on the result.
	localparam logic [1:0] ST_BALANCED   = 2'd0;
	localparam logic [1:0] ST_INCOMPLETE = 2'd1;
	localparam logic [1:0] ST_CORRUPTED  = 2'd2;
	localparam logic [1:0] ST_OVERFLOW   = 2'd3;

	// Line failure state.
	typedef enum logic [1:0] {
		FAIL_NONE,
		FAIL_CORRUPT,
		FAIL_OVERFLOW
	} fail_t;

	// One decoded input character.
	typedef struct packed {
		logic               is_open;
		logic               is_close;
		logic [1:0]         code;
		logic [SCORE_W-1:0] score;
	} char_info_t;

	// Score of an illegal closer, indexed by its closer code.
	function automatic logic [SCORE_W-1:0] illegal_score(input logic [1:0] code);
		logic [SCORE_W-1:0] s;
		case (code)
			CODE_PAREN: s = SCORE_W'(3);
			CODE_BRACK: s = SCORE_W'(57);
			CODE_BRACE: s = SCORE_W'(1197);
			default:    s = SCORE_W'(25137);
		endcase
		return s;
	endfunction

endpackage

/* hdl/bnc_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module bnc_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port, and read data registered from the address.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hdl/bnc_decode.sv */
// Character classifier: sorts a byte into opener, closer or other, and gives
// its closer code and corruption score. Depends on bnc_pkg.
module bnc_decode (
	input  logic [bnc_pkg::CHAR_W-1:0] character,
	output bnc_pkg::char_info_t        info
);
	import bnc_pkg::*;

	// Map each bracket byte to its class and code; any other byte scores 0.
	always_comb begin
		info = '0;
		case (character)
			CH_LPAREN: begin info.is_open = 1'b1; info.code = CODE_PAREN; end
			CH_LBRACK: begin info.is_open = 1'b1; info.code = CODE_BRACK; end
			CH_LBRACE: begin info.is_open = 1'b1; info.code = CODE_BRACE; end
			CH_LANGLE: begin info.is_open = 1'b1; info.code = CODE_ANGLE; end
			CH_RPAREN: begin info.is_close = 1'b1; info.code = CODE_PAREN; end
			CH_RBRACK: begin info.is_close = 1'b1; info.code = CODE_BRACK; end
			CH_RBRACE: begin info.is_close = 1'b1; info.code = CODE_BRACE; end
			CH_RANGLE: begin info.is_close = 1'b1; info.code = CODE_ANGLE; end
			default: info = '0;
		endcase
		if (info.is_close) begin
			info.score = illegal_score(info.code);
		end
	end

endmodule

/* hdl/bracket_nesting_checker.sv */
// Bracket nesting checker top level: stack control, completion walk and
// result register. Depends on bnc_pkg, bnc_decode and bnc_ram.
//
// Usage: the input channel carries one character per request with an
// end-of-line mark; the output channel carries one result per line
// (status, corruption score, completion score). Both channels use valid
// and stall; a request moves on an edge with valid high and stall low.
// Throughput is one character per cycle while in_stall is low. The closer
// stack lives in a RAM with a registered read; the address for the next
// top of stack is issued in the same cycle as each push or pop, and a push
// is forwarded from a register for the cycle after it.
// The result of a balanced, corrupted or overflowed line is in the output
// register in the cycle after its last character. An incomplete line with
// entries left on the stack first walks the stack, one entry per cycle
// unless the last step waits on a full output register, and its result is
// loaded at the last walk step; input is stalled for the whole walk.
// Reset clears the stack depth, the failure state and the output register;
// the stack RAM needs no clearing. While a result waits under out_stall,
// input is stalled as well, so no character is taken until it is drained.
module bracket_nesting_checker #(
	parameter int STACK_DEPTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [bnc_pkg::CHAR_W-1:0]  character,
	input  logic                        end_of_line,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  line_status,
	output logic [bnc_pkg::SCORE_W-1:0] error_score,
	output logic [bnc_pkg::COMP_W-1:0]  completion_score
);
	import bnc_pkg::*;

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam logic [DW-1:0] DEPTH_MAX = DW'(STACK_DEPTH);
	localparam logic [DW-1:0] DEPTH_ONE = DW'(1);
	localparam logic [DW-1:0] DEPTH_TWO = DW'(2);

	typedef enum logic {
		RUN,
		WALK
	} state_t;

	state_t             state_q;
	logic [DW-1:0]      depth_q;
	fail_t              fail_q;
	logic [SCORE_W-1:0] err_q;
	logic [1:0]         tos_q;
	logic               pushed_q;
	logic [DW-1:0]      walk_q;
	logic [COMP_W-1:0]  comp_q;
	logic               out_valid_q;
	logic [1:0]         status_q;
	logic [SCORE_W-1:0] out_err_q;
	logic [COMP_W-1:0]  out_comp_q;

	char_info_t         info;
	logic [1:0]         rd_data;
	logic [1:0]         top;
	logic               out_free;
	logic               accept;
	logic               live;
	logic               do_push;
	logic               do_pop;
	logic               do_overflow;
	logic               do_corrupt;
	logic [DW-1:0]      depth_after;
	fail_t              fail_after;
	logic [SCORE_W-1:0] err_after;
	logic               walk_last;
	logic               walk_step;
	logic [COMP_W-1:0]  comp_next;
	logic [DW-1:0]      rd_ptr;
	logic               out_load;

	bnc_decode u_decode (
		.character (character),
		.info      (info)
	);

	bnc_ram #(
		.WIDTH (2),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (do_push),
		.waddr (depth_q[AW-1:0]),
		.wdata (info.code),
		.raddr (rd_ptr[AW-1:0]),
		.rdata (rd_data)
	);

	// The output register can take a result when empty or being drained.
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q == WALK) || !out_free;
	assign accept   = in_valid && !in_stall;

	// Top of stack: a push from the previous cycle is not yet in the read data, so it comes from a register.
	assign top = pushed_q ? tos_q : rd_data;

	// Character processing against the stack.
	always_comb begin
		live        = accept && (fail_q == FAIL_NONE);
		do_push     = live && info.is_open && (depth_q != DEPTH_MAX);
		do_overflow = live && info.is_open && (depth_q == DEPTH_MAX);
		do_pop      = live && !info.is_open && info.is_close && (depth_q != '0)
			&& (top == info.code);
		do_corrupt  = live && !info.is_open && !do_pop;
		depth_after = depth_q;
		fail_after  = fail_q;
		err_after   = err_q;
		if (do_push) begin
			depth_after = depth_q + DEPTH_ONE;
		end
		if (do_pop) begin
			depth_after = depth_q - DEPTH_ONE;
		end
		if (do_overflow) begin
			fail_after = FAIL_OVERFLOW;
		end
		if (do_corrupt) begin
			fail_after = FAIL_CORRUPT;
			err_after  = info.score;
		end
	end

	// Completion walk: score = score * 5 + code + 1, top entry first.
	always_comb begin
		walk_last = (walk_q == DEPTH_ONE);
		walk_step = !walk_last || out_free;
		comp_next = {comp_q[COMP_W-3:0], 2'b00} + comp_q + COMP_W'(top) + COMP_W'(1);
	end

	// A result is loaded at a line end that needs no walk, or at the last walk step.
	assign out_load = (accept && end_of_line
		&& ((fail_after != FAIL_NONE) || (depth_after == '0)))
		|| ((state_q == WALK) && walk_step && walk_last);

	// Read address: the top of the stack as it stands after this cycle.
	always_comb begin
		if (state_q == WALK) begin
			rd_ptr = walk_step ? (walk_q - DEPTH_TWO) : (walk_q - DEPTH_ONE);
		end else begin
			rd_ptr = depth_after - DEPTH_ONE;
		end
	end

	// State, stack bookkeeping and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= RUN;
			depth_q     <= '0;
			fail_q      <= FAIL_NONE;
			err_q       <= '0;
			tos_q       <= '0;
			pushed_q    <= 1'b0;
			walk_q      <= '0;
			comp_q      <= '0;
			out_valid_q <= 1'b0;
			status_q    <= ST_BALANCED;
			out_err_q   <= '0;
			out_comp_q  <= '0;
		end else begin
			pushed_q <= do_push;
			if (do_push) begin
				tos_q <= info.code;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				RUN: begin
					if (accept) begin
						if (end_of_line) begin
							depth_q <= '0;
							fail_q  <= FAIL_NONE;
							err_q   <= '0;
							if (fail_after == FAIL_CORRUPT) begin
								status_q   <= ST_CORRUPTED;
								out_err_q  <= err_after;
								out_comp_q <= '0;
							end else if (fail_after == FAIL_OVERFLOW) begin
								status_q   <= ST_OVERFLOW;
								out_err_q  <= '0;
								out_comp_q <= '0;
							end else if (depth_after == '0) begin
								status_q   <= ST_BALANCED;
								out_err_q  <= '0;
								out_comp_q <= '0;
							end else begin
								state_q <= WALK;
								walk_q  <= depth_after;
								comp_q  <= '0;
							end
						end else begin
							depth_q <= depth_after;
							fail_q  <= fail_after;
							err_q   <= err_after;
						end
					end
				end
				WALK: begin
					if (walk_step) begin
						comp_q <= comp_next;
						walk_q <= walk_q - DEPTH_ONE;
						if (walk_last) begin
							state_q    <= RUN;
							status_q   <= ST_INCOMPLETE;
							out_err_q  <= '0;
							out_comp_q <= comp_next;
						end
					end
				end
				default: state_q <= RUN;
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign line_status      = status_q;
	assign error_score      = out_err_q;
	assign completion_score = out_comp_q;

	// The stack never holds more entries than it has room for.
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_MAX)
		else $error("stack depth beyond capacity");

	// A walk always has at least one entry left to score.
	a_walk_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == WALK |-> walk_q != '0)
		else $error("completion walk with no entries");

	// No character is taken while the stack is being walked.
	a_walk_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == WALK |-> in_stall)
		else $error("input accepted during completion walk");

	// Only a corrupted line carries a corruption score.
	a_err_only_corrupt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_CORRUPTED |-> out_err_q == '0)
		else $error("corruption score on a line that is not corrupted");

endmodule
